@@ rtl/ookd_pkg.sv @@
// Shared types, constants and register codes for the OOK pulse-width frame decoder.
package ookd_pkg;

  // Datapath widths
  localparam int COUNT_BITS    = 16;
  localparam int WORD_BITS     = 32;
  localparam int CODE_BITS     = 32;
  localparam int NBITS_BITS    = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SYNC_MIN   = 3'd0,
    REG_ZERO_ABOVE = 3'd1,
    REG_ZERO_BELOW = 3'd2,
    REG_ONE_ABOVE  = 3'd3,
    REG_ONE_BELOW  = 3'd4,
    REG_FRAME_BITS = 3'd5
  } ookd_reg_idx_t;

  // Reset values of the configuration registers
  localparam logic [COUNT_BITS-1:0] SYNC_MIN_RST   = 16'd100;
  localparam logic [COUNT_BITS-1:0] ZERO_ABOVE_RST = 16'd3;
  localparam logic [COUNT_BITS-1:0] ZERO_BELOW_RST = 16'd12;
  localparam logic [COUNT_BITS-1:0] ONE_ABOVE_RST  = 16'd15;
  localparam logic [COUNT_BITS-1:0] ONE_BELOW_RST  = 16'd28;
  localparam logic [NBITS_BITS-1:0] FRAME_BITS_RST = 6'd24;

  // Pulse width windows handed to the classifier
  typedef struct packed {
    logic [COUNT_BITS-1:0] zero_above;
    logic [COUNT_BITS-1:0] zero_below;
    logic [COUNT_BITS-1:0] one_above;
    logic [COUNT_BITS-1:0] one_below;
  } ookd_window_cfg_t;

  // Classifier verdict
  typedef struct packed {
    logic is_zero;
    logic is_one;
  } ookd_bit_class_t;

endpackage

@@ rtl/ookd_in_if.sv @@
// Input channel: one sampled receiver pin level per transfer.
interface ookd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

@@ rtl/ookd_out_if.sv @@
// Result channel: one decoded code word per transfer.
interface ookd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ookd_pkg::CODE_BITS-1:0] code_word;

  modport source (output valid, output code_word, input ready);
  modport sink   (input valid, input code_word, output ready);
endinterface

@@ rtl/ookd_bit_class.sv @@
// Classifies a measured high pulse width as a zero bit, a one bit or neither.
module ookd_bit_class (
  input  logic [ookd_pkg::COUNT_BITS-1:0] width,
  input  ookd_pkg::ookd_window_cfg_t      win,
  output ookd_pkg::ookd_bit_class_t       verdict
);

  logic in_zero;
  logic in_one;

  // Exclusive windows; the zero window wins when both match
  always_comb begin
    in_zero = (width > win.zero_above) && (width < win.zero_below);
    in_one  = (width > win.one_above) && (width < win.one_below);
    verdict.is_zero = in_zero;
    verdict.is_one  = in_one && !in_zero;
  end

endmodule

@@ rtl/ook_pulse_width_frame_decoder.sv @@
// Top level of the OOK pulse-width frame decoder.
//
// in_if carries one sampled receiver pin level per transfer (one tick each).
// The tick counter, sync detection, pulse width capture and bit shifting
// all update at the edge on which the sample transfers, so one sample is
// taken every cycle while the output register is free or being drained.
// When a sample completes a frame, the code word lands in the output
// register and out_if.valid rises in the cycle after that transfer.
// First received bit is the most significant frame bit in code_word.
// The output register holds one result; while it is full and out_if.ready
// is low, in_if.ready drops, so no sample is taken that could overwrite it.
// When the register is drained in the same cycle, a new sample is taken.
// cfg_we/cfg_index/cfg_data write one of six registers per cycle: sync gap
// minimum, the zero and one width windows, and the frame length. Unknown
// indexes are ignored. Reset (rst_n low, synchronous) restores register
// defaults, empties the output register and returns to sync wait.
module ook_pulse_width_frame_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  ookd_in_if.sink                            in_if,
  ookd_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [ookd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ookd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CB = ookd_pkg::COUNT_BITS;
  localparam int WB = ookd_pkg::WORD_BITS;
  localparam int NB = ookd_pkg::NBITS_BITS;

  // Configuration registers
  logic [CB-1:0] sync_min_r;
  logic [NB-1:0] frame_bits_r;
  ookd_pkg::ookd_window_cfg_t win_r;

  // Decoder state
  logic          receiving_r, receiving_nxt;
  logic [CB-1:0] tick_r, tick_nxt;
  logic [CB-1:0] high_width_r, high_width_nxt;
  logic [WB-1:0] shift_r, shift_nxt;
  logic [NB-1:0] nbits_r, nbits_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic [ookd_pkg::CODE_BITS-1:0] code_r, code_nxt;

  logic          in_xfer;
  logic [CB-1:0] tick_inc;
  logic [NB-1:0] nbits_inc;
  logic [WB-1:0] shift_in;
  logic          emit;
  ookd_pkg::ookd_bit_class_t verdict;

  // Take a sample whenever the result slot is free or being drained
  assign in_if.ready     = !out_valid_r || out_if.ready;
  assign in_xfer         = in_if.valid && in_if.ready;
  assign out_if.valid    = out_valid_r;
  assign out_if.code_word = code_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r      <= ookd_pkg::SYNC_MIN_RST;
      win_r.zero_above <= ookd_pkg::ZERO_ABOVE_RST;
      win_r.zero_below <= ookd_pkg::ZERO_BELOW_RST;
      win_r.one_above  <= ookd_pkg::ONE_ABOVE_RST;
      win_r.one_below  <= ookd_pkg::ONE_BELOW_RST;
      frame_bits_r    <= ookd_pkg::FRAME_BITS_RST;
    end else if (cfg_we) begin
      unique case (ookd_pkg::ookd_reg_idx_t'(cfg_index))
        ookd_pkg::REG_SYNC_MIN:   sync_min_r       <= CB'(cfg_data);
        ookd_pkg::REG_ZERO_ABOVE: win_r.zero_above <= CB'(cfg_data);
        ookd_pkg::REG_ZERO_BELOW: win_r.zero_below <= CB'(cfg_data);
        ookd_pkg::REG_ONE_ABOVE:  win_r.one_above  <= CB'(cfg_data);
        ookd_pkg::REG_ONE_BELOW:  win_r.one_below  <= CB'(cfg_data);
        ookd_pkg::REG_FRAME_BITS: frame_bits_r     <= cfg_data[NB-1:0];
        default: ;
      endcase
    end
  end

  // Width classification of the captured high pulse
  ookd_bit_class u_bit_class (
    .width   (high_width_r),
    .win     (win_r),
    .verdict (verdict)
  );

  // Saturating tick, shifted word and bit count candidates
  assign tick_inc  = (tick_r == {CB{1'b1}}) ? tick_r : tick_r + CB'(1);
  assign nbits_inc = nbits_r + NB'(1);
  assign shift_in  = {shift_r[WB-2:0], verdict.is_one};

  // Next decoder state for the sample on the input
  always_comb begin
    receiving_nxt  = receiving_r;
    tick_nxt       = tick_r;
    high_width_nxt = high_width_r;
    shift_nxt      = shift_r;
    nbits_nxt      = nbits_r;
    emit           = 1'b0;
    if (in_xfer) begin
      tick_nxt = tick_inc;
      if (!receiving_r) begin
        // Sync wait: a rising level ends the gap
        if (in_if.pin_level) begin
          if (tick_inc > sync_min_r) begin
            receiving_nxt = 1'b1;
            shift_nxt     = '0;
            nbits_nxt     = '0;
          end
          tick_nxt = '0;
        end
      end else if (!in_if.pin_level && high_width_r == '0) begin
        // Falling edge: capture the high pulse width
        high_width_nxt = tick_inc;
        tick_nxt       = '0;
      end else if (in_if.pin_level && high_width_r != '0) begin
        // Rising edge: decide the bit
        if (verdict.is_zero || verdict.is_one) begin
          shift_nxt      = shift_in;
          nbits_nxt      = nbits_inc;
          high_width_nxt = '0;
          tick_nxt       = '0;
          if (nbits_inc >= frame_bits_r) begin
            receiving_nxt = 1'b0;
            emit          = 1'b1;
          end
        end else begin
          // Bad width: abort, tick counter kept
          receiving_nxt  = 1'b0;
          high_width_nxt = '0;
        end
      end
    end
  end

  // Result register load and drain
  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    code_nxt      = code_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      code_nxt      = ookd_pkg::CODE_BITS'(shift_in);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      tick_r       <= '0;
      high_width_r <= '0;
      shift_r      <= '0;
      nbits_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      receiving_r  <= receiving_nxt;
      tick_r       <= tick_nxt;
      high_width_r <= high_width_nxt;
      shift_r      <= shift_nxt;
      nbits_r      <= nbits_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

endmodule

@@ rtl/ookd_checker.sv @@
// Port-level checks for the OOK pulse-width frame decoder, bound to the top level.
module ookd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ookd_pkg::CODE_BITS-1:0]     code_word
);

  // A held result keeps its valid until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A held result keeps its code word
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(code_word))
    else $error("code word changed while stalled");

  // No sample is taken while the result slot is full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("sample taken over a stalled result");

  // A new result only follows a sample transfer
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a sample transfer");

endmodule

bind ook_pulse_width_frame_decoder ookd_checker u_ookd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .code_word (out_if.code_word)
);

@@ dv/tb_ook_pulse_width_frame_decoder.sv @@
// Self-checking testbench for the OOK pulse-width frame decoder: driven frames, predicted code words.
module tb_ook_pulse_width_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_GAP  = 4;

  // Indexes past the last register; writes to them must change nothing
  localparam logic [ookd_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ookd_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  // Predicts code words from the accepted pin samples and checks the transfers
  class code_word_scoreboard;
    logic [ookd_pkg::COUNT_BITS-1:0] sync_min;
    logic [ookd_pkg::COUNT_BITS-1:0] zero_above;
    logic [ookd_pkg::COUNT_BITS-1:0] zero_below;
    logic [ookd_pkg::COUNT_BITS-1:0] one_above;
    logic [ookd_pkg::COUNT_BITS-1:0] one_below;
    logic [ookd_pkg::NBITS_BITS-1:0] frame_len;

    bit                              receiving;
    logic [ookd_pkg::COUNT_BITS-1:0] ticks;
    logic [ookd_pkg::COUNT_BITS-1:0] pulse_width;
    logic [ookd_pkg::WORD_BITS-1:0]  shift_word;
    logic [ookd_pkg::NBITS_BITS-1:0] bit_count;

    logic [ookd_pkg::CODE_BITS-1:0]  expected_words[$];
    int unsigned                     errors;
    int unsigned                     words_predicted;

    function new();
      sync_min    = ookd_pkg::SYNC_MIN_RST;
      zero_above  = ookd_pkg::ZERO_ABOVE_RST;
      zero_below  = ookd_pkg::ZERO_BELOW_RST;
      one_above   = ookd_pkg::ONE_ABOVE_RST;
      one_below   = ookd_pkg::ONE_BELOW_RST;
      frame_len   = ookd_pkg::FRAME_BITS_RST;
      receiving   = 1'b0;
      ticks       = '0;
      pulse_width = '0;
      shift_word  = '0;
      bit_count   = '0;
      errors      = 0;
      words_predicted = 0;
    endfunction

    function void write_reg(logic [ookd_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [ookd_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        ookd_pkg::REG_SYNC_MIN:   sync_min   = val;
        ookd_pkg::REG_ZERO_ABOVE: zero_above = val;
        ookd_pkg::REG_ZERO_BELOW: zero_below = val;
        ookd_pkg::REG_ONE_ABOVE:  one_above  = val;
        ookd_pkg::REG_ONE_BELOW:  one_below  = val;
        ookd_pkg::REG_FRAME_BITS: frame_len  = val[ookd_pkg::NBITS_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(bit lvl);
      bit data_bit;
      // counter saturates
      if (ticks != {ookd_pkg::COUNT_BITS{1'b1}}) ticks++;
      // sync wait: a long enough low gap followed by a high starts a frame
      if (!receiving) begin
        if (lvl) begin
          if (ticks > sync_min) begin
            receiving  = 1'b1;
            shift_word = '0;
            bit_count  = '0;
          end
          ticks = '0;
        end
        return;
      end
      // falling edge: capture the high pulse width
      if (!lvl && pulse_width == 0) begin
        pulse_width = ticks;
        ticks       = '0;
        return;
      end
      if (!(lvl && pulse_width != 0)) return;
      // rising edge: classify, zero window first
      if (pulse_width > zero_above && pulse_width < zero_below) begin
        data_bit = 1'b0;
      end else if (pulse_width > one_above && pulse_width < one_below) begin
        data_bit = 1'b1;
      end else begin
        // abort, counter left alone
        receiving   = 1'b0;
        pulse_width = '0;
        return;
      end
      shift_word  = {shift_word[ookd_pkg::WORD_BITS-2:0], data_bit};
      bit_count   = bit_count + 1'b1;
      pulse_width = '0;
      ticks       = '0;
      if (bit_count >= frame_len) begin
        receiving = 1'b0;
        expected_words.push_back(shift_word[ookd_pkg::CODE_BITS-1:0]);
        words_predicted++;
      end
    endfunction

    function void check_word(logic [ookd_pkg::CODE_BITS-1:0] got);
      logic [ookd_pkg::CODE_BITS-1:0] want;
      if (expected_words.size() == 0) begin
        $error("code_word: no result expected, actual %h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        $error("code_word: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                               cfg_we;
  logic [ookd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [ookd_pkg::CFG_DATA_BITS-1:0] cfg_data;

  ookd_in_if  in_ch ();
  ookd_out_if out_ch ();

  code_word_scoreboard sb = new();

  int src_idle_pct;
  int snk_idle_pct;
  int samples_sent;
  int stall_cycles;
  bit hold_req;

  ook_pulse_width_frame_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // One pin sample transfer, with random idle cycles in front
  task automatic send_sample(input bit lvl);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.pin_level <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(lvl);
    samples_sent++;
  endtask

  task automatic send_run(input bit lvl, input int count);
    for (int k = 0; k < count; k++) send_sample(lvl);
  endtask

  // Stop offering samples and wait until every predicted word has come out
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ookd_pkg::CFG_IDX_BITS-1:0] idx,
                           input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ookd_pkg::CFG_DATA_BITS'(val);
    @(posedge clk);
    sb.write_reg(idx, ookd_pkg::CFG_DATA_BITS'(val));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_windows(input int za, input int zb, input int oa, input int ob);
    write_reg(ookd_pkg::REG_ZERO_ABOVE, za);
    write_reg(ookd_pkg::REG_ZERO_BELOW, zb);
    write_reg(ookd_pkg::REG_ONE_ABOVE, oa);
    write_reg(ookd_pkg::REG_ONE_BELOW, ob);
  endtask

  // Fixed frame: optional sync gap, nbits pulses MSB first, closing high edge
  task automatic send_word(input logic [63:0] bits, input int nbits, input int w0,
                           input int w1, input bit with_sync);
    if (with_sync) send_run(1'b0, sb.sync_min);
    for (int i = nbits - 1; i >= 0; i--) begin
      send_run(1'b1, bits[i] ? w1 : w0);
      send_run(1'b0, 2);
    end
    send_run(1'b1, 1);
  endtask

  // Random width inside the window for the given bit, 0 if the window is empty
  function automatic int pulse_width_for(input bit one);
    int lo, hi;
    lo = one ? sb.one_above : sb.zero_above;
    hi = one ? sb.one_below : sb.zero_below;
    if (hi - lo < 2) return 0;
    return $urandom_range(lo + 1, (hi - 1 < lo + 8) ? hi - 1 : lo + 8);
  endfunction

  // Random frame; bad_pct of the pulses get a random width
  task automatic send_frame(input int nbits, input int bad_pct);
    int w;
    bit b;
    send_run(1'b0, sb.sync_min + $urandom_range(0, 2));
    for (int i = 0; i < nbits; i++) begin
      b = 1'($urandom_range(1));
      w = pulse_width_for(b);
      if (w == 0) w = pulse_width_for(!b);
      if (w == 0 || $urandom_range(99) < bad_pct) w = $urandom_range(1, 30);
      send_run(1'b1, w);
      send_run(1'b0, $urandom_range(1, 4));
    end
    send_run(1'b1, 1);
  endtask

  task automatic random_setup();
    int za, zb, oa, ob;
    za = $urandom_range(0, 4);
    zb = za + $urandom_range(0, 8);
    oa = zb + $urandom_range(0, 5) - 2;
    if (oa < 0) oa = 0;
    ob = oa + $urandom_range(0, 10);
    write_reg(ookd_pkg::REG_SYNC_MIN, $urandom_range(0, 12));
    set_windows(za, zb, oa, ob);
    case ($urandom_range(9))
      0:       write_reg(ookd_pkg::REG_FRAME_BITS, $urandom);
      1:       write_reg(ookd_pkg::REG_FRAME_BITS, $urandom_range(6, 40));
      default: write_reg(ookd_pkg::REG_FRAME_BITS, $urandom_range(0, 5));
    endcase
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                          $urandom);
  endtask

  // Mostly well-formed frames, some truncated frames and line noise, after an optional hold-off run
  task automatic run_phase(input int src_pct, input int snk_pct, input bit with_hold);
    int first_sample, first_word, eff_len, noise_len;
    settle();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    first_sample = samples_sent;
    first_word   = sb.words_predicted;
    if (with_hold) begin
      // receiver holds off while one-bit frames keep coming: input must stall
      write_reg(ookd_pkg::REG_SYNC_MIN, 2);
      set_windows(1, 4, 4, 8);
      write_reg(ookd_pkg::REG_FRAME_BITS, 1);
      hold_req = 1'b1;
      repeat (4) send_frame(1, 0);
      settle();
    end
    do begin
      settle();
      random_setup();
      eff_len = (sb.frame_len == 0) ? 1 : sb.frame_len;
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(9))
          0: begin
            noise_len = $urandom_range(3, 20);
            for (int k = 0; k < noise_len; k++) send_sample(1'($urandom_range(1)));
          end
          1:       send_frame($urandom_range(0, eff_len - 1), 30);
          default: send_frame(eff_len, 3);
        endcase
      end
    end while (samples_sent - first_sample < 185 || sb.words_predicted - first_word < 12);
  endtask

  // Result side: random back-pressure, or a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Check result transfers; count cycles without any transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_word(out_ch.code_word);
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      stall_cycles++;
    else
      stall_cycles = 0;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("ook_pulse_width_frame_decoder regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = ookd_pkg::REG_SYNC_MIN;
    cfg_data        = '0;
    hold_req        = 1'b0;
    samples_sent    = 0;
    stall_cycles    = 0;
    src_idle_pct    = 17;
    snk_idle_pct    = 55;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset windows: frames at the window edges
    send_word(64'h00A5_C396, 24, 4, 27, 1'b1);
    send_word(64'h005A_3C69, 24, 11, 16, 1'b1);
    // gap one tick short of sync, then a short gap: no frame starts
    send_run(1'b0, 99);
    send_run(1'b1, 2);
    send_run(1'b0, 40);
    send_run(1'b1, 1);
    // width between the windows aborts the frame
    send_run(1'b0, 100);
    send_run(1'b1, 13);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    settle();

    // all-zero and all-one 32-bit words
    write_reg(ookd_pkg::REG_SYNC_MIN, 3);
    set_windows(1, 4, 4, 8);
    write_reg(ookd_pkg::REG_FRAME_BITS, 32);
    send_word(64'h0, 32, 2, 6, 1'b1);
    send_word(64'hFFFF_FFFF, 32, 3, 5, 1'b1);
    settle();
    // zero frame length behaves as one bit
    write_reg(ookd_pkg::REG_FRAME_BITS, 0);
    send_word(64'h1, 1, 2, 7, 1'b1);
    send_word(64'h0, 1, 3, 5, 1'b1);
    settle();
    // longer than the word: oldest bits drop off the top
    write_reg(ookd_pkg::REG_FRAME_BITS, 40);
    send_word(64'hA5_F00F_1234, 40, 2, 7, 1'b1);
    settle();
    // frame length data masked to six bits
    write_reg(ookd_pkg::REG_FRAME_BITS, 16'hFFFF);
    send_word({$urandom, $urandom}, 63, 2, 6, 1'b1);
    settle();
    // overlapping windows: zero wins
    set_windows(1, 6, 2, 9);
    write_reg(ookd_pkg::REG_FRAME_BITS, 4);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    send_word(64'hA, 4, 4, 7, 1'b1);
    send_word(64'h6, 4, 5, 8, 1'b1);
    settle();
    // register extremes: empty zero window, one window covering everything
    write_reg(ookd_pkg::REG_SYNC_MIN, 0);
    set_windows(0, 0, 0, 16'hFFFF);
    write_reg(ookd_pkg::REG_FRAME_BITS, 8);
    write_reg(REG_SPARE_HI, 16'h0000);
    send_word(64'h3C, 8, 9, 1, 1'b1);
    settle();
    set_windows(16'hFFFF, 16'hFFFF, 0, 16'hFFFF);
    send_word(64'h96, 8, 3, 2, 1'b1);
    settle();
    // both windows empty: every pulse aborts
    write_reg(ookd_pkg::REG_ONE_ABOVE, 16'hFFFF);
    send_word(64'h0F, 8, 2, 3, 1'b1);
    settle();
    // counter saturation: never syncs at the top value, syncs one below it
    write_reg(ookd_pkg::REG_SYNC_MIN, 16'hFFFF);
    set_windows(1, 4, 4, 8);
    write_reg(ookd_pkg::REG_FRAME_BITS, 3);
    send_run(1'b0, 70000);
    settle();
    write_reg(ookd_pkg::REG_SYNC_MIN, 16'hFFFE);
    send_word(64'h5, 3, 2, 6, 1'b0);

    run_phase(17, 55, 1'b0);
    run_phase(55, 17, 1'b0);
    run_phase(0, 0, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ook_pulse_width_frame_decoder regression: pass");
    else
      $display("ook_pulse_width_frame_decoder regression: fail");
    $finish;
  end

endmodule
